FILE: rtl/core/rc4_stream_cipher_core_defines.svh
// ----------------------------------------------------------------------------
// RC4 core assertion macros
// Shared property wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef RC4_STREAM_CIPHER_CORE_DEFINES_SVH
`define RC4_STREAM_CIPHER_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RC4_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// next-cycle implication, disabled in reset
`define RC4_ASSERT_NXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

// fixed-latency implication, disabled in reset
`define RC4_ASSERT_DLY6(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##6 (b)) \
		else $error("assertion failed");

`endif

FILE: rtl/core/rc4_pkg.sv
// ----------------------------------------------------------------------------
// RC4 package
// Types, action codes and sizing constants for the RC4 core.
// ----------------------------------------------------------------------------
package rc4_pkg;

	localparam int MAX_KEY_BYTES = 256;
	localparam int KEY_AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
	localparam int LEN_W  = $clog2(MAX_KEY_BYTES + 1);

	localparam logic [1:0] ACT_KEY    = 2'd0;
	localparam logic [1:0] ACT_SCHED  = 2'd1;
	localparam logic [1:0] ACT_DATA   = 2'd2;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] key_index;
		logic [7:0] key_byte;
		logic [8:0] key_length;
		logic [7:0] data_byte;
		logic       end_of_message;
	} rc4_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_out;
	} rc4_out_t;

	typedef struct packed {
		logic       clear;
		logic       wr_en;
		logic [7:0] wr_addr;
		logic [7:0] wr_data;
		logic [7:0] rd_addr;
	} perm_req_t;

	typedef struct packed {
		logic              wr_en;
		logic [KEY_AW-1:0] wr_addr;
		logic [7:0]        wr_data;
		logic [KEY_AW-1:0] rd_addr;
	} key_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_KS_RD_I,
		ST_KS_RD_J,
		ST_KS_WR_I,
		ST_KS_WR_J,
		ST_DT_RD_I,
		ST_DT_RD_J,
		ST_DT_WR_I,
		ST_DT_WR_J,
		ST_DT_OUT
	} rc4_state_t;

endpackage

FILE: rtl/core/rc4_key_mem.sv
// ----------------------------------------------------------------------------
// RC4 key store
// Single write port, single registered read port; contents undefined until written.
// ----------------------------------------------------------------------------
module rc4_key_mem (
	input  logic              clk,
	input  rc4_pkg::key_req_t req,
	output logic [7:0]        rd_data
);
	import rc4_pkg::*;

	logic [7:0] mem_q [MAX_KEY_BYTES];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		rd_data <= mem_q[req.rd_addr];
	end

endmodule

FILE: rtl/core/rc4_perm_mem.sv
// ----------------------------------------------------------------------------
// RC4 permutation store
// 256x8 array with per-entry valid bits; an entry not written since the
// last clear reads as its own address (identity).
// ----------------------------------------------------------------------------
module rc4_perm_mem (
	input  logic               clk,
	input  logic               arst_n,
	input  rc4_pkg::perm_req_t req,
	output logic [7:0]         rd_data
);
	import rc4_pkg::*;

	logic [7:0] mem_q [256];
	logic [255:0] valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.clear) begin
			valid_q <= '0;
		end else if (req.wr_en) begin
			valid_q[req.wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		rd_data <= valid_q[req.rd_addr] ? mem_q[req.rd_addr] : req.rd_addr;
	end

endmodule

FILE: rtl/core/rc4_seq.sv
// ----------------------------------------------------------------------------
// RC4 sequencer
// Command decode, index registers and the shared three-input byte adder
// that serves both the key schedule and the keystream generator.
// ----------------------------------------------------------------------------
module rc4_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  rc4_pkg::rc4_in_t   item,
	output logic               busy,
	output logic               done,
	output rc4_pkg::rc4_out_t  result,
	output rc4_pkg::perm_req_t perm_req,
	input  logic [7:0]         perm_rd,
	output rc4_pkg::key_req_t  key_req,
	input  logic [7:0]         key_rd
);
	import rc4_pkg::*;

	rc4_state_t state_q, state_d;

	logic [7:0]        i_q, j_q;
	logic [7:0]        si_q, sj_q, t_q;
	logic [7:0]        data_q;
	logic              eom_q;
	logic [KEY_AW-1:0] k_q;
	logic [LEN_W-1:0]  len_q;
	logic              done_q;
	rc4_out_t          result_q;

	logic [7:0] add_a, add_b, add_c, sum;
	logic       accept;
	logic       key_ok;
	logic [8:0] len_sat;
	logic       k_wrap;
	logic [7:0] ks;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	assign sum    = add_a + add_b + add_c;
	assign key_ok = ({1'b0, item.key_index} < 9'(MAX_KEY_BYTES));
	assign len_sat = (item.key_length == 9'd0) ? 9'd1 :
		(item.key_length > 9'(MAX_KEY_BYTES)) ? 9'(MAX_KEY_BYTES) : item.key_length;
	assign k_wrap = ((LEN_W'(k_q) + LEN_W'(1)) == len_q);
	// S[t] was read in the same cycle S[j] got rewritten
	assign ks = (t_q == j_q) ? si_q : perm_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		perm_req         = '0;
		perm_req.rd_addr = i_q;
		key_req.wr_en    = 1'b0;
		key_req.wr_addr  = item.key_index[KEY_AW-1:0];
		key_req.wr_data  = item.key_byte;
		key_req.rd_addr  = k_q;
		add_a            = j_q;
		add_b            = 8'd0;
		add_c            = 8'd0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (item.action)
						ACT_KEY: key_req.wr_en = key_ok;
						ACT_SCHED: begin
							perm_req.clear = 1'b1;
							state_d        = ST_KS_RD_I;
						end
						ACT_DATA: state_d = ST_DT_RD_I;
						default: ;
					endcase
				end
			end
			ST_KS_RD_I: state_d = ST_KS_RD_J;
			ST_KS_RD_J: begin
				add_b            = key_rd;
				add_c            = perm_rd;
				perm_req.rd_addr = sum;
				state_d          = ST_KS_WR_I;
			end
			ST_KS_WR_I: begin
				perm_req.wr_en   = 1'b1;
				perm_req.wr_addr = i_q;
				perm_req.wr_data = perm_rd;
				state_d          = ST_KS_WR_J;
			end
			ST_KS_WR_J: begin
				perm_req.wr_en   = 1'b1;
				perm_req.wr_addr = j_q;
				perm_req.wr_data = si_q;
				state_d          = (i_q == 8'hFF) ? ST_IDLE : ST_KS_RD_I;
			end
			ST_DT_RD_I: state_d = ST_DT_RD_J;
			ST_DT_RD_J: begin
				add_b            = perm_rd;
				perm_req.rd_addr = sum;
				state_d          = ST_DT_WR_I;
			end
			ST_DT_WR_I: begin
				perm_req.wr_en   = 1'b1;
				perm_req.wr_addr = i_q;
				perm_req.wr_data = perm_rd;
				state_d          = ST_DT_WR_J;
			end
			ST_DT_WR_J: begin
				perm_req.wr_en   = 1'b1;
				perm_req.wr_addr = j_q;
				perm_req.wr_data = si_q;
				add_a            = si_q;
				add_b            = sj_q;
				perm_req.rd_addr = sum;
				state_d          = ST_DT_OUT;
			end
			ST_DT_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// schedule and generator indices and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q    <= 8'd0;
			j_q    <= 8'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_DT_OUT);
			case (state_q)
				ST_IDLE: begin
					if (accept && (item.action == ACT_SCHED)) begin
						i_q <= 8'd0;
						j_q <= 8'd0;
					end else if (accept && (item.action == ACT_DATA)) begin
						i_q <= i_q + 8'd1;
					end
				end
				ST_KS_RD_J, ST_DT_RD_J: j_q <= sum;
				ST_KS_WR_J: begin
					i_q <= i_q + 8'd1;
					if (i_q == 8'hFF) begin
						j_q <= 8'd0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					data_q <= item.data_byte;
					eom_q  <= item.end_of_message;
					if (item.action == ACT_SCHED) begin
						len_q <= LEN_W'(len_sat);
						k_q   <= '0;
					end
				end
			end
			ST_KS_RD_J, ST_DT_RD_J: si_q <= perm_rd;
			ST_DT_WR_I: sj_q <= perm_rd;
			ST_DT_WR_J: t_q <= sum;
			ST_KS_WR_J: k_q <= k_wrap ? '0 : (k_q + KEY_AW'(1));
			ST_DT_OUT: begin
				result_q.out_byte <= data_q ^ ks;
				result_q.last_out <= eom_q;
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/core/rc4_stream_cipher_core.sv
// ----------------------------------------------------------------------------
// RC4 stream cipher core
// Key store, permutation store and a sequencer around one shared byte adder.
// ----------------------------------------------------------------------------
// channel   ports                  transfer when
// -------   --------------------   ----------------
// command   start, busy, item      start && !busy
// result    done, result           done (one cycle)
//
// Key load: busy stays low. Action code 3 is dropped the same way.
// Key schedule: busy throughout; each schedule step makes two permutation
// reads and two writes on the single-write-port permutation store.
// Data byte: busy from DT_RD_I through DT_OUT; result strobed as busy falls.
// After reset the permutation is the identity (valid bits cleared); no sweep.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  rc4_pkg::rc4_in_t  item,
	output logic              done,
	output rc4_pkg::rc4_out_t result
);
	import rc4_pkg::*;

	perm_req_t  perm_req;
	key_req_t   key_req;
	logic [7:0] perm_rd;
	logic [7:0] key_rd;

	rc4_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item     (item),
		.busy     (busy),
		.done     (done),
		.result   (result),
		.perm_req (perm_req),
		.perm_rd  (perm_rd),
		.key_req  (key_req),
		.key_rd   (key_rd)
	);

	rc4_perm_mem u_perm (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (perm_req),
		.rd_data (perm_rd)
	);

	rc4_key_mem u_key (
		.clk     (clk),
		.req     (key_req),
		.rd_data (key_rd)
	);

endmodule

FILE: rtl/core/rc4_checker.sv
// ----------------------------------------------------------------------------
// RC4 port checker
// Timing checks on the command and result ports of the RC4 core.
// ----------------------------------------------------------------------------
`include "rc4_stream_cipher_core_defines.svh"

module rc4_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input rc4_pkg::rc4_in_t  item,
	input logic              done,
	input rc4_pkg::rc4_out_t result
);
	import rc4_pkg::*;

	logic acc_data, acc_sched, acc_quiet;

	assign acc_data  = start && !busy && (item.action == ACT_DATA);
	assign acc_sched = start && !busy && (item.action == ACT_SCHED);
	assign acc_quiet = start && !busy &&
		((item.action == ACT_KEY) || (item.action == ACT_UNUSED));

	`RC4_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)
	`RC4_ASSERT_DLY6(a_data_latency, clk, arst_n, acc_data, done)
	`RC4_ASSERT_NXT(a_quiet_item, clk, arst_n, acc_quiet, !busy && !done)
	`RC4_ASSERT_NXT(a_sched_busy, clk, arst_n, acc_sched, busy && !done)
	`RC4_ASSERT_IMP(a_done_after_busy, clk, arst_n, done && !$isunknown(result), $past(busy))

endmodule

bind rc4_stream_cipher_core rc4_checker u_rc4_checker (.*);

FILE: tb/sv/tb_rc4_stream_cipher_core.sv
// ----------------------------------------------------------------------------
// RC4 stream cipher core testbench
// Drives key loads, key schedules and data bytes through the command channel
// and checks every strobed output byte against a keystream tracker kept in
// step with each accepted transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rc4_stream_cipher_core;
	import rc4_pkg::*;

	localparam int CYCLE_LIMIT  = 600_000;
	localparam int RANDOM_ITEMS = 450;

	// Tracks permutation, key bytes and indices; predicts each data byte.
	class rc4_keystream_tracker;
		bit [7:0] sbox [256];
		bit [7:0] key_mem [256];
		bit [7:0] idx_i;
		bit [7:0] idx_j;
		rc4_out_t pending_outputs [$];
		int errors;

		function new();
			foreach (sbox[n]) sbox[n] = 8'(n);
			idx_i = '0;
			idx_j = '0;
			errors = 0;
		endfunction

		function void swap_sbox(bit [7:0] a, bit [7:0] b);
			bit [7:0] t;
			t = sbox[a];
			sbox[a] = sbox[b];
			sbox[b] = t;
		endfunction

		function void rekey(bit [8:0] len);
			int eff;
			bit [7:0] jj;
			eff = (len == 0) ? 1 : ((len > MAX_KEY_BYTES) ? MAX_KEY_BYTES : int'(len));
			jj = '0;
			foreach (sbox[n]) sbox[n] = 8'(n);
			for (int n = 0; n < 256; n++) begin
				jj = jj + key_mem[n % eff] + sbox[n];
				swap_sbox(8'(n), jj);
			end
			idx_i = '0;
			idx_j = '0;
		endfunction

		function bit [7:0] advance_keystream();
			idx_i = idx_i + 8'd1;
			idx_j = idx_j + sbox[idx_i];
			swap_sbox(idx_i, idx_j);
			return sbox[8'(sbox[idx_i] + sbox[idx_j])];
		endfunction

		function void note_command(rc4_in_t c);
			rc4_out_t r;
			case (c.action)
				ACT_KEY: begin
					if (c.key_index < MAX_KEY_BYTES) key_mem[c.key_index] = c.key_byte;
				end
				ACT_SCHED: rekey(c.key_length);
				ACT_DATA: begin
					r.out_byte = c.data_byte ^ advance_keystream();
					r.last_out = c.end_of_message;
					pending_outputs.push_back(r);
				end
				default: ;
			endcase
		endfunction

		function void check_output(rc4_out_t r);
			rc4_out_t want;
			if (pending_outputs.size() == 0) begin
				$error("unexpected output: out_byte %02h last_out %b", r.out_byte, r.last_out);
				errors++;
				return;
			end
			want = pending_outputs.pop_front();
			if (r.out_byte !== want.out_byte) begin
				$error("out_byte: expected %02h, got %02h", want.out_byte, r.out_byte);
				errors++;
			end
			if (r.last_out !== want.last_out) begin
				$error("last_out: expected %b, got %b", want.last_out, r.last_out);
				errors++;
			end
		endfunction
	endclass

	logic     clk = 1'b0;
	logic     arst_n;
	logic     start;
	logic     busy;
	logic     done;
	rc4_in_t  item;
	rc4_out_t result;

	rc4_keystream_tracker tracker = new();

	bit key_written [256];
	bit idle_on;
	bit counting;
	int random_count;
	int cycles;

	rc4_stream_cipher_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	always #1 clk = ~clk;

	// output checked before the same-edge transfer is predicted
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) tracker.check_output(result);
			if (start && !busy) tracker.note_command(item);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic rc4_in_t make_item(logic [1:0] act);
		rc4_in_t c;
		c = rc4_in_t'({$urandom, $urandom});
		c.action = act;
		return c;
	endfunction

	// every key byte the schedule will read must have been written
	function automatic bit len_ok(bit [8:0] len);
		int eff;
		eff = (len == 0) ? 1 : ((len > MAX_KEY_BYTES) ? MAX_KEY_BYTES : int'(len));
		for (int k = 0; k < eff; k++)
			if (!key_written[k]) return 1'b0;
		return 1'b1;
	endfunction

	task automatic send(input rc4_in_t c);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			repeat (gap) begin
				@(negedge clk);
				start <= 1'b0;
				item  <= rc4_in_t'({$urandom, $urandom});
			end
		end
		@(negedge clk);
		start <= 1'b1;
		item  <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (counting && c.action != ACT_UNUSED) random_count++;
	endtask

	task automatic load_key(input bit [7:0] idx, input bit [7:0] b);
		rc4_in_t c;
		c = make_item(ACT_KEY);
		c.key_index = idx;
		c.key_byte  = b;
		key_written[idx] = 1'b1;
		send(c);
	endtask

	task automatic schedule_key(input bit [8:0] len);
		rc4_in_t c;
		c = make_item(ACT_SCHED);
		c.key_length = len;
		send(c);
	endtask

	task automatic cipher_byte(input bit [7:0] b, input bit eom);
		rc4_in_t c;
		c = make_item(ACT_DATA);
		c.data_byte      = b;
		c.end_of_message = eom;
		send(c);
	endtask

	task automatic noise_item();
		if ($urandom_range(0, 1) == 0) send(make_item(ACT_UNUSED));
		else load_key(8'($urandom), 8'($urandom));
	endtask

	// key load, schedule, then a message; now and then a step is dropped
	task automatic run_session(input bit full);
		int klen;
		int nbytes;
		bit [8:0] slen;
		idle_on = (random_count < RANDOM_ITEMS - 50) && ($urandom_range(0, 2) != 0);
		if (full) klen = 256;
		else if ($urandom_range(0, 11) == 0) klen = $urandom_range(17, 256);
		else klen = $urandom_range(1, 16);
		if (full || $urandom_range(0, 5) != 0) begin
			for (int k = 0; k < klen; k++) begin
				load_key(8'(k), 8'($urandom));
				if ($urandom_range(0, 39) == 0) send(make_item(ACT_UNUSED));
			end
		end
		case ($urandom_range(0, 3))
			0: slen = 9'($urandom_range(1, klen));
			1: slen = 9'($urandom_range(0, 511));
			2: slen = (klen == 1) ? 9'd0 : 9'(klen);
			default: slen = 9'(klen);
		endcase
		if (full) slen = 9'($urandom_range(256, 511));
		if (!len_ok(slen)) slen = len_ok(9'(klen)) ? 9'(klen) : 9'd1;
		if (full || $urandom_range(0, 7) != 0) schedule_key(slen);
		nbytes = $urandom_range(1, 24);
		for (int b = 0; b < nbytes; b++) begin
			if ($urandom_range(0, 15) == 0) noise_item();
			cipher_byte(8'($urandom), (b == nbytes - 1) || ($urandom_range(0, 7) == 0));
		end
	endtask

	initial begin
		arst_n  = 1'b0;
		start   = 1'b0;
		item    = '0;
		idle_on = 1'b1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// keystream straight from the reset permutation
		cipher_byte(8'h00, 1'b0);
		cipher_byte(8'hFF, 1'b1);
		send(make_item(ACT_UNUSED));
		// zero key length behaves as one
		load_key(8'd0, 8'hFF);
		schedule_key(9'd0);
		cipher_byte(8'hA5, 1'b0);
		cipher_byte(8'h5A, 1'b1);
		load_key(8'd1, 8'h00);
		load_key(8'd2, 8'h80);
		load_key(8'd3, 8'h01);
		schedule_key(9'd4);
		cipher_byte(8'h00, 1'b0);
		cipher_byte(8'hFF, 1'b0);
		cipher_byte(8'h3C, 1'b1);
		load_key(8'd255, 8'h00);
		send(rc4_in_t'({2'b11, {34{1'b1}}}));
		schedule_key(9'd1);
		cipher_byte(8'hC3, 1'b1);

		// full key store, then a length of 256 to 511 that saturates to 256
		counting = 1'b1;
		run_session(1'b1);
		while (random_count < RANDOM_ITEMS) run_session(1'b0);

		@(negedge clk);
		start <= 1'b0;
		while (tracker.pending_outputs.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending_outputs.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
